FILE: sv/u8dv_pkg.sv
// shared types, constants and helpers for the utf-8 stream decoder/validator
`timescale 1ns / 1ps

package u8dv_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int CHAR_COUNT_W    = 32;
  localparam int CP_W            = 21;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;

  localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN_TWO  = 3'd2;
  localparam logic [2:0] SEQ_LEN_THREE = 3'd3;
  localparam logic [2:0] SEQ_LEN_FOUR = 3'd4;

  localparam logic ITEM_CODEPOINT = 1'b0;
  localparam logic ITEM_SUMMARY   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } u8dv_in_t;

  typedef struct packed {
    logic [CP_W-1:0]         codepoint;
    logic                    item_kind;
    logic                    string_valid;
    logic [CHAR_COUNT_W-1:0] char_count;
    logic                    last_result;
  } u8dv_out_t;

  // up to two results produced by one request
  typedef struct packed {
    logic      v0;
    logic      v1;
    u8dv_out_t r0;
    u8dv_out_t r1;
  } u8dv_push_t;

  // range checks applied once the last continuation byte is in
  function automatic logic value_ok(input logic [CP_W-1:0] v, input logic [2:0] len);
    logic ok;
    begin
      if (len == SEQ_LEN_TWO) begin
        ok = (v >= MIN_TWO_BYTE);
      end else if (len == SEQ_LEN_THREE) begin
        ok = (v >= MIN_THREE_BYTE) && !((v >= SURR_LO) && (v <= SURR_HI));
      end else begin
        ok = (v >= MIN_FOUR_BYTE) && (v <= MAX_SCALAR);
      end
      return ok;
    end
  endfunction

endpackage

FILE: sv/u8dv_core.sv
// decode state and per-byte decode logic
`timescale 1ns / 1ps

module u8dv_core #(
  parameter int COUNT_WIDTH = u8dv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  u8dv_pkg::u8dv_in_t   step_in,
  output u8dv_pkg::u8dv_push_t step_out
);

  logic [1:0]                   pend_r, pend_nxt;
  logic [2:0]                   len_r, len_nxt;
  logic [u8dv_pkg::CP_W-1:0]    pv_r, pv_nxt;
  logic                         err_r, err_nxt;
  logic [COUNT_WIDTH-1:0]       cnt_r, cnt_nxt;

  logic [7:0]                   b;
  logic                         eos;
  logic                         a_good;
  logic                         a_err;
  logic [u8dv_pkg::CP_W-1:0]    a_cp;
  logic [u8dv_pkg::CP_W-1:0]    pv_sh;
  logic [1:0]                   pend_dec;
  logic [COUNT_WIDTH-1:0]       cnt_upd;
  logic [u8dv_pkg::CHAR_COUNT_W-1:0] cnt_sat;
  u8dv_pkg::u8dv_out_t          item_r;
  u8dv_pkg::u8dv_out_t          summ_r;

  assign b        = step_in.data_byte;
  assign eos      = step_in.end_of_string;
  assign pv_sh    = {pv_r[u8dv_pkg::CP_W-7:0], b[5:0]};
  assign pend_dec = pend_r - 2'd1;

  // clamp the running count to the 32-bit summary field
  generate
    if (COUNT_WIDTH > u8dv_pkg::CHAR_COUNT_W) begin : g_sat
      assign cnt_sat = (|cnt_upd[COUNT_WIDTH-1:u8dv_pkg::CHAR_COUNT_W]) ? '1
                       : cnt_upd[u8dv_pkg::CHAR_COUNT_W-1:0];
    end else begin : g_ext
      assign cnt_sat = u8dv_pkg::CHAR_COUNT_W'(cnt_upd);
    end
  endgenerate

  always_comb begin
    pend_nxt = pend_r;
    len_nxt  = len_r;
    pv_nxt   = pv_r;
    err_nxt  = err_r;
    a_good   = 1'b0;
    a_err    = 1'b0;
    a_cp     = '0;

    if (!err_r) begin
      if (pend_r == 2'd0) begin
        if (!b[7]) begin
          a_good = 1'b1;
          a_cp   = u8dv_pkg::CP_W'(b);
        end else if (b[7:5] == 3'b110) begin
          len_nxt = u8dv_pkg::SEQ_LEN_TWO; pend_nxt = 2'd1;
          pv_nxt  = u8dv_pkg::CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          len_nxt = u8dv_pkg::SEQ_LEN_THREE; pend_nxt = 2'd2;
          pv_nxt  = u8dv_pkg::CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          len_nxt = u8dv_pkg::SEQ_LEN_FOUR; pend_nxt = 2'd3;
          pv_nxt  = u8dv_pkg::CP_W'(b[2:0]);
        end else begin
          a_err = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        a_err = 1'b1;
      end else begin
        pv_nxt   = pv_sh;
        pend_nxt = pend_dec;
        if (pend_dec == 2'd0) begin
          if (u8dv_pkg::value_ok(pv_sh, len_r)) begin
            a_good  = 1'b1;
            a_cp    = pv_sh;
            len_nxt = u8dv_pkg::SEQ_LEN_NONE;
            pv_nxt  = '0;
          end else begin
            a_err = 1'b1;
          end
        end
      end
      // string ends mid-sequence
      if (eos && !a_err && (pend_nxt != 2'd0)) begin
        a_err = 1'b1;
      end
    end

    if (a_err) begin
      err_nxt  = 1'b1;
      pend_nxt = 2'd0;
      len_nxt  = u8dv_pkg::SEQ_LEN_NONE;
      pv_nxt   = '0;
      a_cp     = u8dv_pkg::REPLACEMENT_CP;
    end

    cnt_upd = (a_good && !(&cnt_r)) ? cnt_r + COUNT_WIDTH'(1) : cnt_r;
    cnt_nxt = cnt_upd;

    item_r.codepoint    = a_cp;
    item_r.item_kind    = u8dv_pkg::ITEM_CODEPOINT;
    item_r.string_valid = 1'b0;
    item_r.char_count   = '0;
    item_r.last_result  = !eos;

    summ_r.codepoint    = '0;
    summ_r.item_kind    = u8dv_pkg::ITEM_SUMMARY;
    summ_r.string_valid = !err_nxt;
    summ_r.char_count   = cnt_sat;
    summ_r.last_result  = 1'b1;

    if (eos) begin
      pend_nxt = 2'd0;
      len_nxt  = u8dv_pkg::SEQ_LEN_NONE;
      pv_nxt   = '0;
      err_nxt  = 1'b0;
      cnt_nxt  = '0;
    end

    if (a_good || a_err) begin
      step_out.v0 = 1'b1;
      step_out.r0 = item_r;
      step_out.v1 = eos;
      step_out.r1 = summ_r;
    end else begin
      step_out.v0 = eos;
      step_out.r0 = summ_r;
      step_out.v1 = 1'b0;
      step_out.r1 = summ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      len_r  <= u8dv_pkg::SEQ_LEN_NONE;
      pv_r   <= '0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (step_en) begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      pv_r   <= pv_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: sv/u8dv_queue.sv
// small result queue taking up to two entries per cycle
`timescale 1ns / 1ps

module u8dv_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  u8dv_pkg::u8dv_push_t push_in,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8dv_pkg::u8dv_out_t  out_data
);

  u8dv_pkg::u8dv_out_t                 mem_r [u8dv_pkg::QUEUE_DEPTH];
  logic [u8dv_pkg::QUEUE_IDX_W-1:0]    head_r, head_nxt;
  logic [u8dv_pkg::QUEUE_IDX_W-1:0]    tail_r, tail_nxt;
  logic [u8dv_pkg::QUEUE_IDX_W-1:0]    tail_p1;
  logic [u8dv_pkg::QUEUE_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                                push0;
  logic                                push1;
  logic                                pop;

  assign push0     = push_en && push_in.v0;
  assign push1     = push_en && push_in.v0 && push_in.v1;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[head_r];
  assign tail_p1   = tail_r + u8dv_pkg::QUEUE_IDX_W'(1);
  // need space for two results, independent of the output side
  assign room      = (cnt_r <= u8dv_pkg::QUEUE_CNT_W'(u8dv_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    head_nxt = pop ? head_r + u8dv_pkg::QUEUE_IDX_W'(1) : head_r;
    tail_nxt = push1 ? tail_r + u8dv_pkg::QUEUE_IDX_W'(2)
             : (push0 ? tail_p1 : tail_r);
    cnt_nxt  = cnt_r + u8dv_pkg::QUEUE_CNT_W'(push0) + u8dv_pkg::QUEUE_CNT_W'(push1)
             - u8dv_pkg::QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[tail_r] <= push_in.r0;
    end
    if (push1) begin
      mem_r[tail_p1] <= push_in.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: sv/utf8_stream_decoder_validator.sv
// top level of the streaming utf-8 decoder and validator
`timescale 1ns / 1ps

// usage
//   in_*  : one raw byte per request, end_of_string set on the last byte of a string
//   out_* : codepoint items (U+FFFD marks the first error of a string) and,
//           after the last byte, one summary item with string_valid and char_count
//   last_result marks the final result that a byte produced; a byte gives 0, 1 or 2
// path: an accepted byte is held in the input register, decoded from it once the
//   queue has room, and its results are written into the result queue behind out_*
// throughput: one byte per cycle while the queue has room; the single-pass decode
//   between input register and result queue limits it; a string's last byte, if it
//   yields a codepoint item, makes two results, which drain one per ready cycle
// stall: a four-entry result queue sits between decode and out_*; the input
//   register holds its byte while fewer than two queue slots are free, and
//   in_ready drops only when that register is full and blocked
// reset: rst_n (synchronous, active low) empties the input register and the
//   queue and clears the decode state and good-codepoint count

module utf8_stream_decoder_validator #(
  parameter int COUNT_WIDTH = u8dv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8dv_pkg::u8dv_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output u8dv_pkg::u8dv_out_t out_data
);

  // input register
  logic                 in_vld_r;
  u8dv_pkg::u8dv_in_t   in_dat_r;
  logic                 room;
  logic                 advance;
  u8dv_pkg::u8dv_push_t step_res;

  // decode the held byte once the queue can take both possible results
  assign advance  = in_vld_r && room;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_dat_r <= in_data;
    end
  end

  // per-byte decode and string state
  u8dv_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) core_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .step_in (in_dat_r),
    .step_out(step_res)
  );

  // result queue decoupling decode from the receiver
  u8dv_queue queue_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (advance),
    .push_in  (step_res),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: sv/u8dv_chk.sv
// port-level checks for the utf-8 decoder, bound to the top level
`timescale 1ns / 1ps

module u8dv_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input u8dv_pkg::u8dv_out_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // summary carries no codepoint and closes the byte's results
  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == u8dv_pkg::ITEM_SUMMARY) |->
      (out_data.codepoint == '0) && out_data.last_result)
    else $error("malformed summary item");

  // codepoint items are scalar values with empty summary fields
  a_codepoint_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == u8dv_pkg::ITEM_CODEPOINT) |->
      !out_data.string_valid && (out_data.char_count == '0)
      && (out_data.codepoint <= u8dv_pkg::MAX_SCALAR)
      && ((out_data.codepoint < u8dv_pkg::SURR_LO)
          || (out_data.codepoint > u8dv_pkg::SURR_HI)))
    else $error("malformed codepoint item");

endmodule

bind utf8_stream_decoder_validator u8dv_chk chk_i (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
